@@ src/sqlss_pkg.sv @@
// ----------------------------------------------------------------------------
// sqlss_pkg
// Shared character codes, result kinds and the per-byte result bundle of the
// SQL statement splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package sqlss_pkg;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SEMICOLON = 8'h3B;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Slot positions inside one bundle, in emission order.
	localparam int SLOT_SPACE = 0;
	localparam int SLOT_MAIN  = 1;
	localparam int SLOT_END   = 2;
	localparam int NUM_SLOTS  = 3;

	// Everything one input byte produces: an optional held space, an optional
	// character or marker, and an optional end-of-input marker.
	typedef struct packed {
		logic       has_space;
		logic       has_main;
		logic       main_kind;
		logic [7:0] main_byte;
		logic       has_end;
	} bundle_t;

endpackage

`default_nettype wire

@@ src/sqlss_if.sv @@
// ----------------------------------------------------------------------------
// sqlss_if
// Valid/ready channels of the splitter: query bytes in, statement items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sqlss_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_query;

	modport source (output valid, output text_byte, output end_of_query, input ready);
	modport sink   (input valid, input text_byte, input end_of_query, output ready);
endinterface

interface sqlss_out_if;
	logic       valid;
	logic       ready;
	logic       item_kind;
	logic [7:0] out_byte;
	logic       last_result;

	modport source (output valid, output item_kind, output out_byte, output last_result,
		input ready);
	modport sink   (input valid, input item_kind, input out_byte, input last_result,
		output ready);
endinterface

`default_nettype wire

@@ src/sqlss_front.sv @@
// ----------------------------------------------------------------------------
// sqlss_front
// Accepts query bytes, tracks quoting and whitespace state, and builds the
// bundle of results that each byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module sqlss_front
	import sqlss_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	sqlss_in_if.sink      query,
	input  wire logic     queue_full,
	output logic          push,
	output bundle_t       push_data
);

	logic inside_quote_q, quote_is_double_q, escape_active_q;
	logic space_pending_q, statement_nonempty_q;
	logic inside_quote_n, quote_is_double_n, escape_active_n;
	logic space_pending_n, statement_nonempty_n;
	logic       accept;
	logic [7:0] c;
	logic       is_blank;
	logic [7:0] close_quote;
	bundle_t    bundle;

	assign query.ready = !queue_full;
	assign accept      = query.valid && query.ready;
	assign c           = query.text_byte;
	assign is_blank    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	assign close_quote = quote_is_double_q ? CH_DQUOTE : CH_SQUOTE;

	always_comb begin
		inside_quote_n       = inside_quote_q;
		quote_is_double_n    = quote_is_double_q;
		escape_active_n      = escape_active_q;
		space_pending_n      = space_pending_q;
		statement_nonempty_n = statement_nonempty_q;
		bundle               = '0;

		if (inside_quote_q) begin
			bundle.has_main  = 1'b1;
			bundle.main_kind = KIND_CHAR;
			bundle.main_byte = c;
			if (c == CH_BACKSLASH) begin
				escape_active_n = !escape_active_q;
			end else begin
				if (!escape_active_q && c == close_quote) begin
					inside_quote_n = 1'b0;
				end
				escape_active_n = 1'b0;
			end
		end else if (is_blank) begin
			if (statement_nonempty_q) begin
				space_pending_n = 1'b1;
			end
		end else if (c == CH_SEMICOLON) begin
			space_pending_n = 1'b0;
			if (statement_nonempty_q) begin
				bundle.has_main  = 1'b1;
				bundle.main_kind = KIND_END;
			end
			statement_nonempty_n = 1'b0;
		end else begin
			bundle.has_space     = space_pending_q;
			space_pending_n      = 1'b0;
			bundle.has_main      = 1'b1;
			bundle.main_kind     = KIND_CHAR;
			bundle.main_byte     = c;
			statement_nonempty_n = 1'b1;
			if (c == CH_DQUOTE || c == CH_SQUOTE) begin
				inside_quote_n    = 1'b1;
				quote_is_double_n = (c == CH_DQUOTE);
				escape_active_n   = 1'b0;
			end
		end

		// End of input closes any open statement and returns to the reset state.
		if (query.end_of_query) begin
			bundle.has_end       = statement_nonempty_n;
			inside_quote_n       = 1'b0;
			quote_is_double_n    = 1'b0;
			escape_active_n      = 1'b0;
			space_pending_n      = 1'b0;
			statement_nonempty_n = 1'b0;
		end
	end

	assign push      = accept && (bundle.has_space || bundle.has_main || bundle.has_end);
	assign push_data = bundle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_quote_q       <= 1'b0;
			quote_is_double_q    <= 1'b0;
			escape_active_q      <= 1'b0;
			space_pending_q      <= 1'b0;
			statement_nonempty_q <= 1'b0;
		end else if (accept) begin
			inside_quote_q       <= inside_quote_n;
			quote_is_double_q    <= quote_is_double_n;
			escape_active_q      <= escape_active_n;
			space_pending_q      <= space_pending_n;
			statement_nonempty_q <= statement_nonempty_n;
		end
	end

endmodule

`default_nettype wire

@@ src/sqlss_queue.sv @@
// ----------------------------------------------------------------------------
// sqlss_queue
// Short FIFO of result bundles between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sqlss_queue
	import sqlss_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire bundle_t  push_data,
	input  wire logic     pop,
	output bundle_t       head,
	output logic          empty,
	output logic          full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bundle_t            entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign head    = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ src/sqlss_back.sv @@
// ----------------------------------------------------------------------------
// sqlss_back
// Unpacks the bundle at the head of the queue into single result items, one
// per output request.
// ----------------------------------------------------------------------------
`default_nettype none

module sqlss_back
	import sqlss_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire bundle_t  head,
	input  wire logic     head_valid,
	output logic          pop,
	sqlss_out_if.source   result
);

	logic [NUM_SLOTS-1:0] sent_q;
	logic [NUM_SLOTS-1:0] present, pending, pick, rest;
	logic                 take;

	assign present[SLOT_SPACE] = head.has_space;
	assign present[SLOT_MAIN]  = head.has_main;
	assign present[SLOT_END]   = head.has_end;
	assign pending = present & ~sent_q;
	// Lowest pending slot goes first.
	assign pick    = pending & (~pending + NUM_SLOTS'(1));
	assign rest    = pending & ~pick;

	always_comb begin
		result.item_kind = KIND_CHAR;
		result.out_byte  = 8'h00;
		if (pick[SLOT_SPACE]) begin
			result.out_byte = CH_SPACE;
		end else if (pick[SLOT_MAIN]) begin
			result.item_kind = head.main_kind;
			result.out_byte  = head.main_byte;
		end else begin
			result.item_kind = KIND_END;
		end
	end

	assign result.valid       = head_valid && (pending != '0);
	assign result.last_result = (rest == '0);
	assign take               = result.valid && result.ready;
	assign pop                = take && (rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q <= '0;
		end else if (take) begin
			sent_q <= (rest == '0) ? '0 : (sent_q | pick);
		end
	end

endmodule

`default_nettype wire

@@ src/sql_statement_splitter.sv @@
// ----------------------------------------------------------------------------
// sql_statement_splitter
// Splits query text into statements at unquoted semicolons.
// ----------------------------------------------------------------------------
// A query byte is taken in every cycle in which the bundle queue has room,
// and its results are registered in the queue and then leave one per cycle
// while the output is ready. Each byte causes zero to three results (a held
// space, the byte or a statement marker, and a final marker at end of query),
// so while the output is ready the sustained input rate is one byte per cycle
// as long as bytes average one result or less, and otherwise follows the
// output side at one result per cycle. QUEUE_DEPTH sets how many bytes' worth
// of results can wait between the two sides.
`default_nettype none

module sql_statement_splitter
	import sqlss_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sqlss_in_if.sink    query,
	sqlss_out_if.source result
);

	logic    push, pop, empty, full;
	bundle_t push_data, head;

	sqlss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.query      (query),
		.queue_full (full),
		.push       (push),
		.push_data  (push_data)
	);

	sqlss_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	sqlss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

`default_nettype wire
